// ===== sv/slxff_pkg.sv =====
package slxff_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam logic [7:0] SYNC_RESET = 8'h55;
    localparam logic [7:0] MIN_LENGTH = 8'd3;
    localparam int GROUP_BYTES = 4;
    localparam int OUT_DATA_W = 40;

    // controller -> datapath
    typedef struct packed {
        logic sync_load;    // take sync byte as frame byte 0
        logic len_load;     // take length byte as frame byte 1
        logic body_store;   // take a payload byte
        logic check_store;  // take the matching check byte, arm emission
        logic rd_issue;     // read one row of four frame bytes
        logic out_load;     // move the read row into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sync_hit;     // input byte equals the sync value
        logic len_ok;       // input byte is a usable frame length
        logic body_more;    // payload bytes still expected
        logic check_ok;     // input byte equals the running xor
        logic last_group;   // at most four frame bytes left to send
        logic out_free;     // output register can take a beat this cycle
    } sts_t;

endpackage

// ===== sv/sync_length_xor_frame_filter_unit.sv =====
// Byte-stream deframer. Hunt the input for the sync byte (cfg register, 0x55
// after reset); the byte after it is the total frame length N, then N-3
// payload bytes and one check byte that must equal the XOR of sync, N and
// payload. A good frame leaves on the master side whole, four bytes a beat,
// with tlast on its final beat; unused byte lanes of a short beat read zero.
// Drop a frame whose length is below 3 or above STORE_DEPTH right at the
// length byte, and drop a frame with a bad check byte without rescanning it.
// Rate: one input byte per cycle while hunting and receiving. After a good
// check byte the input is held off while the frame is read back from the
// frame memory, one four-byte row per read through its single read port;
// a row is read, then moved into the output register once that is free.
// The last beat sits in the output register while the next bytes are
// already taken. The frame memory needs no clearing after reset.
module sync_length_xor_frame_filter_unit #(
    parameter int STORE_DEPTH = slxff_pkg::STORE_DEPTH_DEF  // 4..256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sync value register
    input  logic                               cfg_we,
    input  logic [7:0]                         cfg_wdata,
    // byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] in_byte
    // frame groups out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2,
    // [31:24] out_byte3, [34:32] group_count, [39:35] zero
    output logic [slxff_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tlast   // frame_last
);

    slxff_pkg::cmd_t cmd;
    slxff_pkg::sts_t sts;

    // sequence hunt, length, body, then readback of the stored frame
    slxff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the frame bytes, running check and the output beat
    slxff_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/slxff_ctrl.sv =====
module slxff_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  slxff_pkg::sts_t    sts,
    output slxff_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_BODY = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_LD   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_HUNT) || (state_reg == ST_LEN)
                      || (state_reg == ST_BODY);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT: begin
                if (accept && sts.sync_hit) begin
                    cmd.sync_load = 1'b1;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN: begin
                if (accept) begin
                    if (sts.len_ok) begin
                        cmd.len_load = 1'b1;
                        state_next   = ST_BODY;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_BODY: begin
                if (accept) begin
                    if (sts.body_more) begin
                        cmd.body_store = 1'b1;
                    end else if (sts.check_ok) begin
                        cmd.check_store = 1'b1;
                        state_next      = ST_RD;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LD;
            end
            ST_LD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.last_group ? ST_HUNT : ST_RD;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/slxff_dp.sv =====
module slxff_dp #(
    parameter int STORE_DEPTH = slxff_pkg::STORE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [7:0]                         cfg_wdata,
    input  logic [7:0]                         s_tdata,
    input  slxff_pkg::cmd_t                    cmd,
    output slxff_pkg::sts_t                    sts,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [slxff_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);

    localparam int ROWS  = (STORE_DEPTH + slxff_pkg::GROUP_BYTES - 1)
                           / slxff_pkg::GROUP_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [8:0] DEPTH_MAX = 9'(STORE_DEPTH);

    logic [7:0]       sync_value_reg;
    logic [7:0]       frame_length_reg;
    logic [7:0]       frame_length_next;
    logic [7:0]       byte_index_reg;
    logic [7:0]       byte_index_next;
    logic [7:0]       running_xor_reg;
    logic [7:0]       running_xor_next;
    logic [7:0]       remain_reg;
    logic [7:0]       remain_next;
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] rd_row_next;

    logic [3:0][7:0]  mem [ROWS];
    logic [3:0][7:0]  rd_data_reg;

    logic             wr_en;
    logic [7:0]       wr_pos;
    logic [ROW_W-1:0] wr_row;
    logic [1:0]       wr_lane;

    logic             m_tvalid_reg;
    logic [3:0][7:0]  m_bytes_reg;
    logic [2:0]       m_count_reg;
    logic             m_last_reg;
    logic [3:0][7:0]  grp_bytes;
    logic [2:0]       grp_count;

    // status toward the controller
    assign sts.sync_hit   = (s_tdata == sync_value_reg);
    assign sts.len_ok     = (s_tdata >= slxff_pkg::MIN_LENGTH)
                            && ({1'b0, s_tdata} <= DEPTH_MAX);
    assign sts.body_more  = ({1'b0, byte_index_reg} + 9'd1) < {1'b0, frame_length_reg};
    assign sts.check_ok   = (s_tdata == running_xor_reg);
    assign sts.last_group = (remain_reg <= 8'd4);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // write position of the byte taken this cycle
    always_comb begin
        wr_en  = cmd.sync_load || cmd.len_load || cmd.body_store || cmd.check_store;
        wr_pos = byte_index_reg;
        if (cmd.sync_load) begin
            wr_pos = 8'd0;
        end else if (cmd.len_load) begin
            wr_pos = 8'd1;
        end else if (cmd.check_store) begin
            wr_pos = frame_length_reg - 8'd1;
        end
    end

    assign wr_row  = wr_pos[ROW_W+1:2];
    assign wr_lane = wr_pos[1:0];

    always_comb begin
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        running_xor_next  = running_xor_reg;
        remain_next       = remain_reg;
        rd_row_next       = rd_row_reg;
        if (cmd.sync_load) begin
            running_xor_next = s_tdata;
        end
        if (cmd.len_load) begin
            frame_length_next = s_tdata;
            running_xor_next  = running_xor_reg ^ s_tdata;
            byte_index_next   = 8'd2;
        end
        if (cmd.body_store) begin
            running_xor_next = running_xor_reg ^ s_tdata;
            byte_index_next  = byte_index_reg + 8'd1;
        end
        if (cmd.check_store) begin
            remain_next = frame_length_reg;
            rd_row_next = '0;
        end
        if (cmd.out_load) begin
            remain_next = sts.last_group ? 8'd0 : remain_reg - 8'd4;
            rd_row_next = rd_row_reg + ROW_W'(1);
        end
    end

    // mask lanes past the valid count
    always_comb begin
        grp_count = sts.last_group ? remain_reg[2:0] : 3'd4;
        for (int j = 0; j < slxff_pkg::GROUP_BYTES; j++) begin
            grp_bytes[j] = (3'(j) < grp_count) ? rd_data_reg[j] : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_lane] <= s_tdata;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        frame_length_reg <= frame_length_next;
        byte_index_reg   <= byte_index_next;
        running_xor_reg  <= running_xor_next;
        remain_reg       <= remain_next;
        rd_row_reg       <= rd_row_next;
        if (cmd.out_load) begin
            m_bytes_reg <= grp_bytes;
            m_count_reg <= grp_count;
            m_last_reg  <= sts.last_group;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg <= slxff_pkg::SYNC_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                sync_value_reg <= cfg_wdata;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_bytes_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/frame_filter_checker.sv =====
`timescale 1ns / 1ps

// Watch the stream ports of the deframer, rebuild its frame state from the
// accepted bytes and compare every output beat with the groups due.
module frame_filter_checker #(
    parameter int STORE_DEPTH = slxff_pkg::STORE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [slxff_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    output int                               fail_count,
    output int                               groups_pending
);

    typedef enum logic [1:0] {
        ST_HUNT = 2'd0,
        ST_LEN  = 2'd1,
        ST_BODY = 2'd2
    } deframe_state_t;

    typedef struct packed {
        logic [3:0][7:0] lanes;
        logic [2:0]      count;
        logic            last;
    } frame_group_t;

    deframe_state_t hunt_state;
    logic [7:0]     sync_reg;
    logic [7:0]     frame_len;
    logic [7:0]     next_pos;
    logic [7:0]     xor_acc;
    logic [7:0]     frame_mem [STORE_DEPTH];
    frame_group_t   groups_due [$];
    int             mismatches = 0;
    int             beat_no = 0;

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        mismatches++;
        $display("%0t: beat %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, beat_no, what, want, got);
    endtask

    // Advance the frame state by one byte; queue the groups of a good frame.
    task automatic absorb_byte(input logic [7:0] b);
        int           pos;
        int           cnt;
        int           last_pos;
        frame_group_t g;
        case (hunt_state)
            ST_LEN: begin
                if (b < slxff_pkg::MIN_LENGTH || int'(b) > STORE_DEPTH) begin
                    hunt_state = ST_HUNT;
                end else begin
                    frame_len    = b;
                    frame_mem[1] = b;
                    xor_acc      = xor_acc ^ b;
                    next_pos     = 8'd2;
                    hunt_state   = ST_BODY;
                end
            end
            ST_BODY: begin
                last_pos = int'(frame_len) - 1;
                if (int'(next_pos) < last_pos) begin
                    frame_mem[next_pos] = b;
                    xor_acc  = xor_acc ^ b;
                    next_pos = next_pos + 8'd1;
                end else begin
                    hunt_state = ST_HUNT;
                    next_pos   = 8'd0;
                    if (b == xor_acc) begin
                        frame_mem[last_pos] = b;
                        pos = 0;
                        while (pos < int'(frame_len)) begin
                            cnt = int'(frame_len) - pos;
                            if (cnt > slxff_pkg::GROUP_BYTES)
                                cnt = slxff_pkg::GROUP_BYTES;
                            for (int j = 0; j < slxff_pkg::GROUP_BYTES; j++)
                                g.lanes[j] = (j < cnt) ? frame_mem[pos + j] : 8'h00;
                            g.count = cnt[2:0];
                            g.last  = (pos + cnt >= int'(frame_len));
                            groups_due.push_back(g);
                            pos += cnt;
                        end
                    end
                end
            end
            default: begin
                hunt_state = ST_HUNT;
                if (b == sync_reg) begin
                    frame_mem[0] = b;
                    xor_acc      = b;
                    next_pos     = 8'd1;
                    hunt_state   = ST_LEN;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        frame_group_t g;
        if (!aresetn) begin
            hunt_state = ST_HUNT;
            sync_reg   = slxff_pkg::SYNC_RESET;
            frame_len  = 8'd0;
            next_pos   = 8'd0;
            xor_acc    = 8'd0;
            groups_due.delete();
        end else begin
            // Drain first: a beat leaving now never stems from a byte taken now.
            if (m_tvalid && m_tready) begin
                if (groups_due.size() == 0) begin
                    report_mismatch("beat with no group due", 40'd0, m_tdata);
                end else begin
                    g = groups_due.pop_front();
                    for (int j = 0; j < slxff_pkg::GROUP_BYTES; j++)
                        if (m_tdata[8*j +: 8] !== g.lanes[j])
                            report_mismatch($sformatf("out_byte%0d", j),
                                            40'(g.lanes[j]), 40'(m_tdata[8*j +: 8]));
                    if (m_tdata[34:32] !== g.count)
                        report_mismatch("group_count", 40'(g.count),
                                        40'(m_tdata[34:32]));
                    if (m_tdata[39:35] !== 5'd0)
                        report_mismatch("pad bits", 40'd0, 40'(m_tdata[39:35]));
                    if (m_tlast !== g.last)
                        report_mismatch("frame_last", 40'(g.last), 40'(m_tlast));
                end
                beat_no++;
            end
            // A byte taken at a register write still sees the old sync value.
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);
            if (cfg_we)
                sync_reg = cfg_wdata;
        end
        fail_count     <= mismatches;
        groups_pending <= groups_due.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Longest quiet stretch of a correct run comes from the forced receiver
    // hold (HOLD_CYCLES); allow several times that.
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 12;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [7:0]                       cfg_wdata = 8'h00;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata = 8'h00;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [slxff_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tlast;

    int         fail_count;
    int         groups_pending;
    int         send_idle_pct = 0;     // chance of a gap before each byte
    int         recv_stall_pct = 0;    // chance m_tready is low in a cycle
    logic       hold_req = 1'b0;       // ask the receiver for its long hold
    int         held = 0;
    int         quiet = 0;
    int         frame_bytes = 0;
    logic [7:0] sync_now = slxff_pkg::SYNC_RESET; // sync byte the block should hunt for
    logic [7:0] body_buf [256];        // payload of the next frame to send

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sync_length_xor_frame_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    frame_filter_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .groups_pending (groups_pending)
    );

    // Receiver: hold off for one long stretch when asked, so the block fills
    // up and stalls its input; otherwise stall at random.
    always @(posedge aclk) begin
        if (hold_req && held < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            held     <= held + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one byte, with optional gaps first; return at the accepting edge
    // with s_tvalid still high so back-to-back beats need no extra step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Send sync, length, payload from body_buf and check byte. A length
    // below 3 stops after the length byte; bad_check spoils the check byte.
    task automatic send_frame(input logic [7:0] len, input bit bad_check);
        logic [7:0] chk;
        chk = sync_now ^ len;
        send_byte(sync_now);
        send_byte(len);
        if (len >= slxff_pkg::MIN_LENGTH) begin
            for (int k = 0; k < int'(len) - 3; k++) begin
                send_byte(body_buf[k]);
                chk = chk ^ body_buf[k];
            end
            if (bad_check)
                chk = chk ^ 8'($urandom_range(255, 1));
            send_byte(chk);
            frame_bytes += int'(len);
        end else begin
            frame_bytes += 2;
        end
    endtask

    task automatic fill_body(input int n);
        for (int k = 0; k < n; k++)
            body_buf[k] = 8'($urandom_range(255));
    endtask

    // Mostly well-formed frames with random payload, mixed with bad checks,
    // short lengths and stray bytes that never match the sync value.
    task automatic send_traffic(input int target);
        int         start;
        int         pick;
        int         len;
        logic [7:0] stray;
        start = frame_bytes;
        while (frame_bytes - start < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 3);
                fill_body(len);
                send_frame(8'(len), 1'b0);
            end else if (pick < 75) begin
                len = $urandom_range(12, 3);
                fill_body(len);
                send_frame(8'(len), 1'b1);
            end else if (pick < 85) begin
                send_frame(8'($urandom_range(2, 0)), 1'b0);
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    stray = 8'($urandom_range(255));
                    if (stray == sync_now)
                        stray = ~stray;
                    send_byte(stray);
                end
            end
        end
    endtask

    // Drop valid, then wait until every due group has left and the block
    // has settled on any trailing byte that produces nothing.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (groups_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Reprogram the sync byte on an idle block and change the idling mix.
    task automatic start_phase(input logic [7:0] sync_val, input int send_pct,
                               input int recv_pct, input bit long_hold);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= sync_val;
        @(posedge aclk);
        cfg_we         <= 1'b0;
        sync_now        = sync_val;
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
        hold_req       <= long_hold;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at the reset sync value, no idling.
        send_frame(8'd3, 1'b0);              // minimal frame: no payload
        send_frame(8'd0, 1'b0);              // short lengths
        send_frame(8'd2, 1'b0);
        body_buf[0] = slxff_pkg::SYNC_RESET; // sync inside a bad frame
        body_buf[1] = 8'd3;
        send_frame(8'd5, 1'b1);
        body_buf[0] = 8'h00;                 // extreme payload values
        body_buf[1] = 8'hFF;
        body_buf[2] = 8'h80;
        send_frame(8'd6, 1'b0);
        body_buf[0] = 8'h7F;
        send_frame(8'd4, 1'b0);              // exactly one full group
        body_buf[1] = 8'h01;
        send_frame(8'd5, 1'b0);              // one-byte tail group

        // Sync of zero: a zero length equal to the sync byte must not
        // restart the hunt.
        start_phase(8'h00, 0, 0, 1'b0);
        send_frame(8'd0, 1'b0);
        send_frame(8'd1, 1'b0);
        send_traffic(PHASE_ITEMS);

        start_phase(8'hFF, 70, 0, 1'b0);
        send_traffic(PHASE_ITEMS);

        start_phase(8'($urandom_range(255)), 0, 70, 1'b0);
        send_traffic(PHASE_ITEMS);

        start_phase(8'($urandom_range(255)), 8, 8, 1'b0);
        send_traffic(PHASE_ITEMS);

        // Back to the reset value under a long receiver hold; open with a
        // three-beat frame so the output fills and the input stalls.
        start_phase(slxff_pkg::SYNC_RESET, 0, 0, 1'b1);
        fill_body(12);
        send_frame(8'd12, 1'b0);
        send_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slxff_pkg.sv
sv/slxff_ctrl.sv
sv/slxff_dp.sv
sv/sync_length_xor_frame_filter_unit.sv
test/frame_filter_checker.sv
test/testbench.sv
